@@ hdl/bpe_pkg.sv @@
// Shared types and constants for the breakpoint envelope evaluator.
// Holds the point record, request and status codes, and the controller to
// datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package bpe_pkg;

  // request codes
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_UPDATE = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_EVAL   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;

  // curve parameter one, 20-bit fraction
  localparam logic [20:0] T_ONE = 21'h100000;

  // one envelope point
  typedef struct packed {
    logic               ctrl;
    logic signed [15:0] y;
    logic        [15:0] x;
  } point_t;

  // source of the evaluated value
  typedef enum logic [1:0] {
    VAL_ZERO,
    VAL_FIRST,
    VAL_LAST,
    VAL_CALC
  } val_sel_t;

  // controller commands to the datapath
  typedef struct packed {
    logic     item_load;
    logic     rd_en;
    logic     wr_en;
    logic     wr_item;
    logic     win_shift;
    logic     last_load;
    logic     calc_start;
    logic     calc_curve;
    logic     val_load;
    val_sel_t val_sel;
    logic     out_load;
  } dp_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic px_lt_rd;
    logic px_le_rd;
    logic seg_hit;
    logic w1_ctrl;
    logic w2_ctrl;
    logic pos_lt_first;
    logic pos_eq_first;
    logic pos_gt_last;
    logic pos_eq_last;
    logic calc_done;
  } dp_stat_t;

endpackage

@@ hdl/bpe_calc.sv @@
// Iterative arithmetic unit: linear interpolation with a bit-serial divider,
// and cubic Bezier evaluation with bisection on the curve parameter.
// Depends on bpe_pkg.
`timescale 1ns / 1ps

module bpe_calc #(
  parameter int BISECT_STEPS = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                curve,
  input  logic         [15:0] pos,
  input  bpe_pkg::point_t     pt_a,
  input  bpe_pkg::point_t     pt_b,
  input  bpe_pkg::point_t     pt_c,
  output logic                done,
  output logic signed  [15:0] result
);

  localparam int SW = $clog2(BISECT_STEPS + 1);

  typedef enum logic [3:0] {
    C_IDLE,
    C_LIN_MUL,
    C_ABS,
    C_DIV,
    C_LIN_ADD,
    C_MID,
    C_CUBE,
    C_WGT,
    C_PROD,
    C_SUM
  } cstate_t;

  cstate_t state;
  bpe_pkg::point_t pa, pb, pc;
  logic        [15:0] pos_r;
  logic        [20:0] t0, t1;
  logic        [19:0] t, t2;
  logic        [40:0] m2;
  logic        [39:0] m3;
  logic        [20:0] w01, w2, w3;
  logic               y_pass;
  logic      [SW-1:0] cnt;
  logic signed [38:0] prod0, prod1, prod2;
  logic signed [33:0] lp;
  logic               neg;
  logic        [16:0] rem;
  logic        [31:0] quo;
  logic         [4:0] dcnt;

  // bisection midpoint and its square
  logic [21:0] tsum;
  logic [19:0] mid;
  logic [39:0] sq;
  assign tsum = 22'(t0) + 22'(t1);
  assign mid  = tsum[20:1];
  assign sq   = mid * mid;

  // weights from the cubic terms
  logic [20:0] u;
  logic [42:0] three_m2;
  logic [20:0] w2n, w3n;
  assign u        = bpe_pkg::T_ONE - {1'b0, t};
  assign three_m2 = 43'({m2, 1'b0}) + 43'(m2);
  assign w2n      = three_m2[40:20];
  assign w3n      = {1'b0, m3[39:20]};

  // multiplier operands, x during bisection and y for the final value
  logic signed [16:0] opa, opb, opc;
  assign opa = y_pass ? {pa.y[15], pa.y} : {1'b0, pa.x};
  assign opb = y_pass ? {pb.y[15], pb.y} : {1'b0, pb.x};
  assign opc = y_pass ? {pc.y[15], pc.y} : {1'b0, pc.x};

  // weighted sum, rounding and saturation
  logic signed [40:0] wsum, xlim, rsum;
  logic signed [20:0] rnd;
  logic signed [15:0] sat;
  assign wsum = 41'(prod0) + 41'(prod1) + 41'(prod2);
  assign xlim = $signed({5'd0, pos_r, 20'd0});
  assign rsum = (wsum + 41'sd524288) >>> 20;
  assign rnd  = rsum[20:0];
  always_comb begin
    if (rnd > 21'sd32767) begin
      sat = 16'sh7fff;
    end else if (rnd < -21'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = rnd[15:0];
    end
  end

  // linear terms and divider step
  logic signed [16:0] dy, dx, yq, ysum;
  logic        [15:0] dw;
  logic        [16:0] trial;
  logic               ge;
  logic        [33:0] mag;
  assign dy    = $signed({pb.y[15], pb.y}) - $signed({pa.y[15], pa.y});
  assign dx    = $signed({1'b0, pos_r - pa.x});
  assign dw    = pb.x - pa.x;
  assign trial = {rem[15:0], quo[31]};
  assign ge    = trial >= {1'b0, dw};
  assign mag   = lp[33] ? 34'(-lp) : 34'(lp);
  assign yq    = neg ? -$signed({1'b0, quo[15:0]}) : $signed({1'b0, quo[15:0]});
  assign ysum  = $signed({pa.y[15], pa.y}) + yq;

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) begin
            pa    <= pt_a;
            pb    <= pt_b;
            pc    <= pt_c;
            pos_r <= pos;
            if (curve) begin
              if (pt_c.x == pt_a.x) begin
                result <= pt_a.y;
                done   <= 1'b1;
              end else begin
                t0     <= '0;
                t1     <= bpe_pkg::T_ONE;
                cnt    <= '0;
                y_pass <= 1'b0;
                state  <= C_MID;
              end
            end else if (pt_b.x <= pt_a.x) begin
              result <= pt_a.y;
              done   <= 1'b1;
            end else begin
              state <= C_LIN_MUL;
            end
          end
        end
        C_LIN_MUL: begin
          lp    <= dy * dx;
          state <= C_ABS;
        end
        C_ABS: begin
          neg   <= lp[33];
          quo   <= mag[31:0];
          rem   <= '0;
          dcnt  <= '0;
          state <= C_DIV;
        end
        C_DIV: begin
          rem  <= ge ? trial - {1'b0, dw} : trial;
          quo  <= {quo[30:0], ge};
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd31) begin
            state <= C_LIN_ADD;
          end
        end
        C_LIN_ADD: begin
          result <= ysum[15:0];
          done   <= 1'b1;
          state  <= C_IDLE;
        end
        C_MID: begin
          t     <= mid;
          t2    <= sq[39:20];
          state <= C_CUBE;
        end
        C_CUBE: begin
          m2    <= t2 * u;
          m3    <= t2 * t;
          state <= C_WGT;
        end
        C_WGT: begin
          w2    <= w2n;
          w3    <= w3n;
          w01   <= bpe_pkg::T_ONE - w2n - w3n;
          state <= C_PROD;
        end
        C_PROD: begin
          prod0 <= $signed({1'b0, w01}) * opa;
          prod1 <= $signed({1'b0, w2}) * opb;
          prod2 <= $signed({1'b0, w3}) * opc;
          state <= C_SUM;
        end
        C_SUM: begin
          if (y_pass) begin
            result <= sat;
            done   <= 1'b1;
            state  <= C_IDLE;
          end else begin
            if (wsum < xlim) begin
              t0 <= {1'b0, t};
            end else begin
              t1 <= {1'b0, t};
            end
            if (cnt == SW'(BISECT_STEPS - 1)) begin
              y_pass <= 1'b1;
              state  <= C_PROD;
            end else begin
              cnt   <= cnt + SW'(1);
              state <= C_MID;
            end
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/bpe_dp.sv @@
// Datapath: point memory, item and window registers, compare flags, value
// registers and the arithmetic unit. Depends on bpe_pkg and bpe_calc.
`timescale 1ns / 1ps

module bpe_dp #(
  parameter int MAX_POINTS   = 16,
  parameter int BISECT_STEPS = 20,
  parameter int AW           = $clog2(MAX_POINTS)
) (
  input  logic                clk,
  input  logic                rst,
  input  bpe_pkg::dp_cmd_t    cmd,
  input  logic       [AW-1:0] raddr,
  input  logic       [AW-1:0] waddr,
  input  logic         [15:0] point_x,
  input  logic signed  [15:0] point_y,
  input  logic                point_control,
  input  logic         [15:0] position,
  output bpe_pkg::dp_stat_t   stat,
  output logic signed  [15:0] value
);

  bpe_pkg::point_t mem [MAX_POINTS];
  bpe_pkg::point_t rdata, item, w0, w1, w2, last, wdata;
  logic [15:0] pos;
  logic signed [15:0] res, calc_res;
  logic calc_done;

  // item request registers
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item.x    <= point_x;
      item.y    <= point_y;
      item.ctrl <= point_control;
      pos       <= position;
    end
  end

  // point memory, registered read
  assign wdata = cmd.wr_item ? item : rdata;
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // segment window and last point
  always_ff @(posedge clk) begin
    if (cmd.win_shift) begin
      w0 <= w1;
      w1 <= w2;
      w2 <= rdata;
    end
    if (cmd.last_load) begin
      last <= rdata;
    end
  end

  // status flags
  assign stat.px_lt_rd     = item.x < rdata.x;
  assign stat.px_le_rd     = item.x <= rdata.x;
  assign stat.seg_hit      = (w1.x <= pos) && (pos <= w2.x);
  assign stat.w1_ctrl      = w1.ctrl;
  assign stat.w2_ctrl      = w2.ctrl;
  assign stat.pos_lt_first = pos < w2.x;
  assign stat.pos_eq_first = pos == w2.x;
  assign stat.pos_gt_last  = pos > last.x;
  assign stat.pos_eq_last  = pos == last.x;
  assign stat.calc_done    = calc_done;

  // arithmetic unit over the window
  bpe_calc #(
    .BISECT_STEPS(BISECT_STEPS)
  ) u_calc (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.calc_start),
    .curve (cmd.calc_curve),
    .pos   (pos),
    .pt_a  (cmd.calc_curve ? w0 : w1),
    .pt_b  (cmd.calc_curve ? w1 : w2),
    .pt_c  (w2),
    .done  (calc_done),
    .result(calc_res)
  );

  // held value and output value
  always_ff @(posedge clk) begin
    if (cmd.val_load) begin
      case (cmd.val_sel)
        bpe_pkg::VAL_ZERO:  res <= '0;
        bpe_pkg::VAL_FIRST: res <= w2.y;
        bpe_pkg::VAL_LAST:  res <= last.y;
        bpe_pkg::VAL_CALC:  res <= calc_res;
        default:            res <= '0;
      endcase
    end
    if (cmd.out_load) begin
      value <= res;
    end
  end

endmodule

@@ hdl/bpe_ctrl.sv @@
// Controller: request sequencing for table edits and evaluation, point
// count, status and output handshake. Depends on bpe_pkg.
`timescale 1ns / 1ps

module bpe_ctrl #(
  parameter int MAX_POINTS = 16,
  parameter int AW         = $clog2(MAX_POINTS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic        [2:0] operation,
  input  logic        [3:0] point_index,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic        [1:0] status,
  output logic        [4:0] point_total,
  output bpe_pkg::dp_cmd_t  cmd,
  output logic     [AW-1:0] raddr,
  output logic     [AW-1:0] waddr,
  input  bpe_pkg::dp_stat_t stat
);

  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int IXW = (CW > 4) ? CW : 4;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_LAST,
    S_INS_SCAN,
    S_SH,
    S_SH_WR,
    S_PUT,
    S_RM_STEP,
    S_RM_WR,
    S_EV_LAST,
    S_EV_FIRST,
    S_EV_CHK,
    S_EV_SCAN,
    S_EV_TEST,
    S_EV_NEXT,
    S_EV_CURVE,
    S_EV_CALC,
    S_DONE
  } state_t;

  state_t state, state_next;
  logic [2:0] op;
  logic [3:0] idx;
  logic [CW-1:0] n, n_next, k, k_next, at, at_next;
  logic [1:0] st, st_next;
  logic [CW-1:0] nm1, kp1, km1;
  logic [IXW-1:0] idx_w, n_w;
  logic bad_idx, out_free;

  assign nm1      = n - CW'(1);
  assign kp1      = k + CW'(1);
  assign km1      = k - CW'(1);
  assign idx_w    = IXW'(idx);
  assign n_w      = IXW'(n);
  assign bad_idx  = idx_w >= n_w;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = state == S_IDLE;

  // next state and datapath commands
  always_comb begin
    state_next = state;
    n_next     = n;
    k_next     = k;
    at_next    = at;
    st_next    = st;
    cmd        = '0;
    raddr      = '0;
    waddr      = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.item_load = 1'b1;
          cmd.val_load  = 1'b1;
          cmd.val_sel   = bpe_pkg::VAL_ZERO;
          st_next       = bpe_pkg::ST_OK;
          state_next    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (op)
          bpe_pkg::OP_INSERT: begin
            if (n >= CW'(MAX_POINTS)) begin
              st_next    = bpe_pkg::ST_FULL;
              state_next = S_DONE;
            end else if (n == '0) begin
              at_next    = '0;
              state_next = S_PUT;
            end else begin
              cmd.rd_en  = 1'b1;
              raddr      = nm1[AW-1:0];
              state_next = S_INS_LAST;
            end
          end
          bpe_pkg::OP_UPDATE: begin
            if (bad_idx) begin
              st_next = bpe_pkg::ST_BAD_INDEX;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wr_item = 1'b1;
              waddr       = idx_w[AW-1:0];
            end
            state_next = S_DONE;
          end
          bpe_pkg::OP_REMOVE: begin
            if (bad_idx) begin
              st_next    = bpe_pkg::ST_BAD_INDEX;
              state_next = S_DONE;
            end else begin
              k_next     = idx_w[CW-1:0];
              state_next = S_RM_STEP;
            end
          end
          bpe_pkg::OP_CLEAR: begin
            n_next     = '0;
            state_next = S_DONE;
          end
          bpe_pkg::OP_EVAL: begin
            if (n < CW'(2)) begin
              state_next = S_DONE;
            end else begin
              cmd.rd_en  = 1'b1;
              raddr      = nm1[AW-1:0];
              state_next = S_EV_LAST;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      // insert: append past the last x, else find the slot
      S_INS_LAST: begin
        if (!stat.px_lt_rd) begin
          at_next    = n;
          state_next = S_PUT;
        end else begin
          k_next     = '0;
          cmd.rd_en  = 1'b1;
          raddr      = '0;
          state_next = S_INS_SCAN;
        end
      end
      S_INS_SCAN: begin
        if ((k == '0) ? stat.px_le_rd : stat.px_lt_rd) begin
          at_next    = k;
          k_next     = n;
          state_next = S_SH;
        end else begin
          k_next     = kp1;
          cmd.rd_en  = 1'b1;
          raddr      = kp1[AW-1:0];
        end
      end
      // move entries up to open the slot
      S_SH: begin
        if (k > at) begin
          cmd.rd_en  = 1'b1;
          raddr      = km1[AW-1:0];
          state_next = S_SH_WR;
        end else begin
          state_next = S_PUT;
        end
      end
      S_SH_WR: begin
        cmd.wr_en  = 1'b1;
        waddr      = k[AW-1:0];
        k_next     = km1;
        state_next = S_SH;
      end
      S_PUT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_item = 1'b1;
        waddr       = at[AW-1:0];
        n_next      = n + CW'(1);
        state_next  = S_DONE;
      end
      // remove: move entries down over the gap
      S_RM_STEP: begin
        if (kp1 < n) begin
          cmd.rd_en  = 1'b1;
          raddr      = kp1[AW-1:0];
          state_next = S_RM_WR;
        end else begin
          n_next     = nm1;
          state_next = S_DONE;
        end
      end
      S_RM_WR: begin
        cmd.wr_en  = 1'b1;
        waddr      = k[AW-1:0];
        k_next     = kp1;
        state_next = S_RM_STEP;
      end
      // evaluate: range checks on the end points
      S_EV_LAST: begin
        cmd.last_load = 1'b1;
        cmd.rd_en     = 1'b1;
        raddr         = '0;
        state_next    = S_EV_FIRST;
      end
      S_EV_FIRST: begin
        cmd.win_shift = 1'b1;
        state_next    = S_EV_CHK;
      end
      S_EV_CHK: begin
        if (stat.pos_lt_first || stat.pos_gt_last) begin
          state_next = S_DONE;
        end else if (stat.pos_eq_first) begin
          cmd.val_load = 1'b1;
          cmd.val_sel  = bpe_pkg::VAL_FIRST;
          state_next   = S_DONE;
        end else if (stat.pos_eq_last) begin
          cmd.val_load = 1'b1;
          cmd.val_sel  = bpe_pkg::VAL_LAST;
          state_next   = S_DONE;
        end else begin
          k_next     = CW'(1);
          cmd.rd_en  = 1'b1;
          raddr      = AW'(1);
          state_next = S_EV_SCAN;
        end
      end
      // segment search in stored order
      S_EV_SCAN: begin
        cmd.win_shift = 1'b1;
        state_next    = S_EV_TEST;
      end
      S_EV_TEST: begin
        if (stat.seg_hit) begin
          if (stat.w1_ctrl && (k >= CW'(2))) begin
            cmd.calc_start = 1'b1;
            cmd.calc_curve = 1'b1;
            state_next     = S_EV_CALC;
          end else if (stat.w2_ctrl && (kp1 < n)) begin
            cmd.rd_en  = 1'b1;
            raddr      = kp1[AW-1:0];
            state_next = S_EV_NEXT;
          end else begin
            cmd.calc_start = 1'b1;
            state_next     = S_EV_CALC;
          end
        end else if (kp1 < n) begin
          k_next     = kp1;
          cmd.rd_en  = 1'b1;
          raddr      = kp1[AW-1:0];
          state_next = S_EV_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      // bring the point after the segment into the window, then start
      S_EV_NEXT: begin
        cmd.win_shift = 1'b1;
        state_next    = S_EV_CURVE;
      end
      S_EV_CURVE: begin
        cmd.calc_start = 1'b1;
        cmd.calc_curve = 1'b1;
        state_next     = S_EV_CALC;
      end
      S_EV_CALC: begin
        if (stat.calc_done) begin
          cmd.val_load = 1'b1;
          cmd.val_sel  = bpe_pkg::VAL_CALC;
          state_next   = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      n           <= '0;
      k           <= '0;
      at          <= '0;
      st          <= bpe_pkg::ST_OK;
      m_tvalid    <= 1'b0;
      status      <= bpe_pkg::ST_OK;
      point_total <= '0;
    end else begin
      state <= state_next;
      n     <= n_next;
      k     <= k_next;
      at    <= at_next;
      st    <= st_next;
      if (state == S_IDLE && s_tvalid) begin
        op  <= operation;
        idx <= point_index;
      end
      if (state == S_DONE && out_free) begin
        m_tvalid    <= 1'b1;
        status      <= st_next;
        point_total <= 5'(n_next);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    n <= CW'(MAX_POINTS))
    else $error("point count above table size");

  a_put_grows: assert property (@(posedge clk) disable iff (rst)
    state == S_PUT |=> n == $past(n) + CW'(1))
    else $error("insert did not grow the table");

  a_shift_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SH_WR |-> k > at)
    else $error("shift write below insert slot");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> state != S_IDLE || $stable(status))
    else $error("held result status changed");

endmodule

@@ hdl/breakpoint_envelope_evaluator.sv @@
// Breakpoint envelope evaluator, top level. One request at a time; a result
// waits in an output register while the next request is taken.
// Reset (rst, synchronous) empties the table and drops any pending result.
`timescale 1ns / 1ps

module breakpoint_envelope_evaluator #(
  parameter int MAX_POINTS   = 16,
  parameter int BISECT_STEPS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // point_index[3:0], point_x[19:4], point_y[35:20], point_control[36],
  // position[52:37], zero fill
  input  logic [55:0] s_tdata,
  // operation[2:0]
  input  logic  [2:0] s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // value[15:0], status[17:16], point_total[22:18], zero fill
  output logic [23:0] m_tdata
);

  localparam int AW = $clog2(MAX_POINTS);

  bpe_pkg::dp_cmd_t  cmd;
  bpe_pkg::dp_stat_t stat;
  logic [AW-1:0] raddr, waddr;
  logic signed [15:0] value;
  logic [1:0] status;
  logic [4:0] point_total;

  bpe_ctrl #(
    .MAX_POINTS(MAX_POINTS),
    .AW        (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .operation  (s_tuser),
    .point_index(s_tdata[3:0]),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .status     (status),
    .point_total(point_total),
    .cmd        (cmd),
    .raddr      (raddr),
    .waddr      (waddr),
    .stat       (stat)
  );

  bpe_dp #(
    .MAX_POINTS  (MAX_POINTS),
    .BISECT_STEPS(BISECT_STEPS),
    .AW          (AW)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .raddr        (raddr),
    .waddr        (waddr),
    .point_x      (s_tdata[19:4]),
    .point_y      ($signed(s_tdata[35:20])),
    .point_control(s_tdata[36]),
    .position     (s_tdata[52:37]),
    .stat         (stat),
    .value        (value)
  );

  assign m_tdata = {1'b0, point_total, status, value};

endmodule

@@ bench/breakpoint_envelope_evaluator_tb.sv @@
// Self-checking bench for the breakpoint envelope evaluator: directed and
// random point-table requests, a local table predictor and a result check.
// Depends on bpe_pkg and the breakpoint_envelope_evaluator top level.
`timescale 1ns / 1ps

module breakpoint_envelope_evaluator_tb;

  localparam int TABLE_DEPTH = 16;
  localparam int STEPS       = 20;
  localparam int QUIET_LO    = 40000;
  localparam int QUIET_HI    = 60000;

  typedef struct {
    logic [2:0]         op;
    logic [3:0]         idx;
    logic [15:0]        px;
    logic signed [15:0] py;
    logic               pc;
    logic [15:0]        pos;
  } env_req_t;

  typedef struct {
    logic signed [15:0] value;
    logic [1:0]         status;
    logic [4:0]         total;
  } env_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  env_req_t pending_reqs[$];
  env_res_t expected_results[$];
  env_req_t cur_req;
  int       errors = 0;
  int       cycle_cnt = 0;
  int       gen_count = 0;

  // local copy of the point table
  logic [15:0]        tbl_x[TABLE_DEPTH];
  logic signed [15:0] tbl_y[TABLE_DEPTH];
  logic               tbl_c[TABLE_DEPTH];
  int                 tbl_n = 0;

  breakpoint_envelope_evaluator DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void curve_weights(input longint t, output longint w01,
                                        output longint w2, output longint w3);
    longint u, t2;
    u   = (longint'(1) << 20) - t;
    t2  = (t * t) >> 20;
    w2  = (3 * t2 * u) >> 20;
    w3  = (t2 * t) >> 20;
    w01 = (longint'(1) << 20) - w2 - w3;
  endfunction

  function automatic logic signed [15:0] line_value(int i, int j, longint p);
    longint x0, x1, y0, y1;
    x0 = tbl_x[i];
    x1 = tbl_x[j];
    y0 = tbl_y[i];
    y1 = tbl_y[j];
    if (x1 <= x0) return tbl_y[i];
    return 16'(y0 + ((y1 - y0) * (p - x0)) / (x1 - x0));
  endfunction

  // cubic bezier with repeated first point, t found by bisection
  function automatic logic signed [15:0] bezier_value(int a, int b, int c, longint p);
    longint t0, t1, t, w01, w2, w3, xt, v;
    t0 = 0;
    t1 = longint'(1) << 20;
    t  = 0;
    if (tbl_x[c] == tbl_x[a]) return tbl_y[a];
    for (int s = 0; s < STEPS; s++) begin
      t = (t0 + t1) >> 1;
      curve_weights(t, w01, w2, w3);
      xt = w01 * tbl_x[a] + w2 * tbl_x[b] + w3 * tbl_x[c];
      if (xt < (p << 20)) t0 = t;
      else t1 = t;
    end
    curve_weights(t, w01, w2, w3);
    v = w01 * longint'(tbl_y[a]) + w2 * longint'(tbl_y[b]) + w3 * longint'(tbl_y[c]);
    v = (v + (longint'(1) << 19)) >>> 20;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] envelope_at(longint p);
    int n, i;
    n = tbl_n;
    if (n < 2) return 0;
    if (p < tbl_x[0] || p > tbl_x[n-1]) return 0;
    if (p == tbl_x[0]) return tbl_y[0];
    if (p == tbl_x[n-1]) return tbl_y[n-1];
    if (n == 2) return line_value(0, 1, p);
    for (i = 0; i + 1 < n; i++)
      if (tbl_x[i] <= p && p <= tbl_x[i+1]) break;
    if (i + 1 >= n) return 0;
    if (tbl_c[i] && i > 0) return bezier_value(i - 1, i, i + 1, p);
    if (tbl_c[i+1] && i + 2 < n) return bezier_value(i, i + 1, i + 2, p);
    return line_value(i, i + 1, p);
  endfunction

  // apply one request to the local table and return its result
  function automatic env_res_t apply_request(env_req_t r);
    env_res_t res;
    int at;
    res.value  = 0;
    res.status = bpe_pkg::ST_OK;
    case (r.op)
      bpe_pkg::OP_INSERT: begin
        if (tbl_n >= TABLE_DEPTH) begin
          res.status = bpe_pkg::ST_FULL;
        end else begin
          if (tbl_n == 0 || r.px >= tbl_x[tbl_n-1]) at = tbl_n;
          else if (r.px <= tbl_x[0]) at = 0;
          else begin
            at = tbl_n;
            for (int k = 1; k < tbl_n; k++)
              if (r.px < tbl_x[k]) begin
                at = k;
                break;
              end
          end
          for (int k = tbl_n; k > at; k--) begin
            tbl_x[k] = tbl_x[k-1];
            tbl_y[k] = tbl_y[k-1];
            tbl_c[k] = tbl_c[k-1];
          end
          tbl_x[at] = r.px;
          tbl_y[at] = r.py;
          tbl_c[at] = r.pc;
          tbl_n++;
        end
      end
      bpe_pkg::OP_UPDATE: begin
        if (r.idx >= tbl_n) begin
          res.status = bpe_pkg::ST_BAD_INDEX;
        end else begin
          tbl_x[r.idx] = r.px;
          tbl_y[r.idx] = r.py;
          tbl_c[r.idx] = r.pc;
        end
      end
      bpe_pkg::OP_REMOVE: begin
        if (r.idx >= tbl_n) begin
          res.status = bpe_pkg::ST_BAD_INDEX;
        end else begin
          for (int k = r.idx; k + 1 < tbl_n; k++) begin
            tbl_x[k] = tbl_x[k+1];
            tbl_y[k] = tbl_y[k+1];
            tbl_c[k] = tbl_c[k+1];
          end
          tbl_n--;
        end
      end
      bpe_pkg::OP_CLEAR: tbl_n = 0;
      bpe_pkg::OP_EVAL: res.value = envelope_at(r.pos);
      default: ;
    endcase
    res.total = 5'(tbl_n);
    return res;
  endfunction

  // queue one request, keeping a rough point count for shaping
  task automatic add_req(logic [2:0] op, logic [3:0] idx, logic [15:0] px,
                         logic [15:0] py, logic pc, logic [15:0] pos);
    env_req_t r;
    r = '{op, idx, px, py, pc, pos};
    pending_reqs.push_back(r);
    if (op == bpe_pkg::OP_INSERT && gen_count < TABLE_DEPTH) gen_count++;
    if (op == bpe_pkg::OP_REMOVE && idx < gen_count) gen_count--;
    if (op == bpe_pkg::OP_CLEAR) gen_count = 0;
  endtask

  function automatic bit idle_now();
    if (cycle_cnt >= QUIET_LO && cycle_cnt < QUIET_HI) return 1'b0;
    return $urandom_range(0, 99) < 15;
  endfunction

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_results.push_back(apply_request(cur_req));
      if (!s_tvalid || s_tready) begin
        if (pending_reqs.size() > 0 && !idle_now()) begin
          cur_req = pending_reqs.pop_front();
          s_tdata  <= {3'b000, cur_req.pos, cur_req.pc, cur_req.py, cur_req.px, cur_req.idx};
          s_tuser  <= cur_req.op;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    env_res_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !idle_now();
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[15:0] !== want.value) begin
            $display("%0t: value mismatch, expected %0d, actual %0d", $time, want.value,
                     $signed(m_tdata[15:0]));
            errors++;
          end
          if (m_tdata[17:16] !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status,
                     m_tdata[17:16]);
            errors++;
          end
          if (m_tdata[22:18] !== want.total) begin
            $display("%0t: point total mismatch, expected %0d, actual %0d", $time,
                     want.total, m_tdata[22:18]);
            errors++;
          end
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int base, span, npts, nev;
    logic [15:0] lo_x;
    // directed: empty table, extremes, full table, bad indexes, special cases
    add_req(bpe_pkg::OP_EVAL, 0, 0, 0, 0, 16'd100);
    add_req(bpe_pkg::OP_REMOVE, 0, 0, 0, 0, 0);
    add_req(bpe_pkg::OP_UPDATE, 4'd15, 16'hFFFF, 16'h7FFF, 1, 0);
    add_req(bpe_pkg::OP_INSERT, 0, 16'hFFFF, 16'h7FFF, 0, 0);
    add_req(bpe_pkg::OP_EVAL, 0, 0, 0, 0, 16'hFFFF);
    add_req(bpe_pkg::OP_INSERT, 0, 16'h0000, 16'h8000, 0, 0);
    add_req(bpe_pkg::OP_EVAL, 0, 0, 0, 0, 16'h8000);
    add_req(bpe_pkg::OP_EVAL, 0, 0, 0, 0, 16'h0000);
    add_req(bpe_pkg::OP_INSERT, 0, 16'h4000, 16'h7FFF, 1, 0);
    add_req(bpe_pkg::OP_EVAL, 0, 0, 0, 0, 16'h2000);
    add_req(bpe_pkg::OP_EVAL, 0, 0, 0, 0, 16'hC000);
    add_req(bpe_pkg::OP_INSERT, 0, 16'h4000, 16'h1000, 0, 0);
    add_req(bpe_pkg::OP_EVAL, 0, 0, 0, 0, 16'h4000);
    add_req(bpe_pkg::OP_UPDATE, 4'd1, 16'hF000, 16'h0100, 0, 0);
    add_req(bpe_pkg::OP_EVAL, 0, 0, 0, 0, 16'h5000);
    add_req(bpe_pkg::OP_REMOVE, 4'd2, 0, 0, 0, 0);
    add_req(bpe_pkg::OP_REMOVE, 4'd9, 0, 0, 0, 0);
    for (int k = 0; k < 14; k++)
      add_req(bpe_pkg::OP_INSERT, 0, 16'(k * 1000), 16'(k * 2000), k[0], 0);
    add_req(bpe_pkg::OP_EVAL, 0, 0, 0, 0, 16'd5500);
    add_req(bpe_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
    add_req(bpe_pkg::OP_EVAL, 0, 0, 0, 0, 16'd10);

    // random: sessions that build a table in a window and then probe it
    while (pending_reqs.size() < 1450) begin
      if ($urandom_range(0, 3) == 0) add_req(bpe_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
      if ($urandom_range(0, 3) == 0) begin
        base = 0;
        span = 65535;
      end else begin
        span = $urandom_range(2, 3000);
        base = $urandom_range(0, 65535 - span);
      end
      npts = ($urandom_range(0, 9) == 0) ? 18 : $urandom_range(2, 8);
      for (int k = 0; k < npts; k++)
        add_req(bpe_pkg::OP_INSERT, 4'($urandom), 16'(base + $urandom_range(0, span)),
                16'($urandom), $urandom_range(0, 9) < 3, 16'($urandom));
      nev = $urandom_range(5, 20);
      for (int k = 0; k < nev; k++) begin
        lo_x = 16'(base + $urandom_range(0, span));
        case ($urandom_range(0, 9))
          0: add_req(bpe_pkg::OP_UPDATE, (gen_count > 0 && $urandom_range(0, 3) != 0) ?
                     4'($urandom_range(0, gen_count - 1)) : 4'($urandom),
                     lo_x, 16'($urandom), $urandom_range(0, 1), 16'($urandom));
          1: add_req(bpe_pkg::OP_REMOVE, (gen_count > 0 && $urandom_range(0, 3) != 0) ?
                     4'($urandom_range(0, gen_count - 1)) : 4'($urandom),
                     16'($urandom), 16'($urandom), $urandom_range(0, 1), 16'($urandom));
          2: add_req(bpe_pkg::OP_EVAL, 4'($urandom), 16'($urandom), 16'($urandom),
                     $urandom_range(0, 1), 16'($urandom));
          default: add_req(bpe_pkg::OP_EVAL, 4'($urandom), 16'($urandom), 16'($urandom),
                           $urandom_range(0, 1), lo_x);
        endcase
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    wait (pending_reqs.size() == 0 && !s_tvalid);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #(20 * 1000000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
